// ----- hdl/crat_pkg.sv -----
// Shared constants, register codes and stage types for the color reading average threshold block.
package crat_pkg;

   localparam int WINDOW_LEN = 10;

   localparam int IN_W    = 16;
   localparam int VAL_W   = 17;
   localparam int THR_W   = 16;
   localparam int SCALE_W = 2;
   localparam int ADDR_W  = 4;
   localparam int DATA_W  = 32;

   localparam int MAG_W   = IN_W + $clog2(WINDOW_LEN);
   localparam int TOTAL_W = MAG_W + 1;
   localparam int AVG_K   = MAG_W + $clog2(WINDOW_LEN);
   localparam int AVG_M_W = MAG_W + 1;
   localparam int AVG_P_W = MAG_W + AVG_M_W;
   localparam logic [AVG_M_W-1:0] AVG_M =
      AVG_M_W'(((longint'(1) << AVG_K) + WINDOW_LEN - 1) / WINDOW_LEN);

   localparam logic [SCALE_W-1:0] PS_KEEP = 2'd0;
   localparam logic [SCALE_W-1:0] PS_LOW  = 2'd1;
   localparam logic [SCALE_W-1:0] PS_MID  = 2'd2;
   localparam logic [SCALE_W-1:0] PS_INV  = 2'd3;

   localparam logic [1:0] REG_POWER_SCALE   = 2'd0;
   localparam logic [1:0] REG_RAW_MODE      = 2'd1;
   localparam logic [1:0] REG_RED_THRESHOLD = 2'd2;

   localparam logic [SCALE_W-1:0] POWER_SCALE_RESET   = PS_MID;
   localparam logic signed [THR_W-1:0] THRESHOLD_RESET = 16'sd75;

   localparam int OP_W   = 18;
   localparam int MUL_W  = 19;
   localparam int PROD_W = OP_W + MUL_W;

   // x*100/160 = x*5/8
   localparam int LOW_K = 3;
   localparam logic [MUL_W-1:0] LOW_M = 19'd5;
   // x*100/1400 = x/14
   localparam int MID_K = 20;
   localparam logic [MUL_W-1:0] MID_M = MUL_W'(((longint'(1) << MID_K) + 13) / 14);
   // (x-1200)*100/(25-1200) = -((x-1200)*4/47)
   localparam int INV_K = 24;
   localparam logic [MUL_W-1:0] INV_M = MUL_W'(((longint'(1) << INV_K) + 46) / 47);
   localparam logic signed [VAL_W-1:0] INV_BASE = 17'sd1200;

   typedef struct packed {
      logic                    valid;
      logic signed [VAL_W-1:0] scaled;
   } sample_type;

   typedef struct packed {
      logic                      valid;
      logic signed [VAL_W-1:0]   scaled;
      logic signed [TOTAL_W-1:0] total;
   } sum_type;

endpackage

// ----- hdl/crat_scale.sv -----
// Reading scaler: reciprocal multiply stage, then shift, sign and keep/raw selection.
module crat_scale (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           advance,
   input  logic                           req_valid,
   input  logic [crat_pkg::IN_W-1:0]      raw_reading,
   input  logic [crat_pkg::SCALE_W-1:0]   power_scale,
   input  logic                           raw_mode,
   output crat_pkg::sample_type           sample
);
   import crat_pkg::*;

   logic                    valid_ff;
   logic                    raw_ff;
   logic [SCALE_W-1:0]      scale_ff;
   logic                    neg_ff;
   logic [IN_W-1:0]         reading_ff;
   logic [PROD_W-1:0]       prod_ff;
   logic signed [VAL_W-1:0] last_ff;

   logic signed [VAL_W-1:0] diff;
   logic [IN_W-1:0]         diff_mag;
   logic [OP_W-1:0]         op_in;
   logic [MUL_W-1:0]        mul_in;
   logic [PROD_W-1:0]       prod_in;
   logic                    neg_in;
   logic [VAL_W-1:0]        quot;
   logic signed [VAL_W-1:0] value;

   always_comb begin
      diff     = $signed({1'b0, raw_reading}) - INV_BASE;
      diff_mag = diff[VAL_W-1] ? IN_W'(-diff) : IN_W'(diff);
      neg_in   = (power_scale == PS_INV) && !diff[VAL_W-1] && (diff != '0);
      case (power_scale)
         PS_LOW: begin
            op_in  = OP_W'(raw_reading);
            mul_in = LOW_M;
         end
         PS_MID: begin
            op_in  = OP_W'(raw_reading);
            mul_in = MID_M;
         end
         PS_INV: begin
            op_in  = {diff_mag, 2'b00};
            mul_in = INV_M;
         end
         default: begin
            op_in  = OP_W'(raw_reading);
            mul_in = '0;
         end
      endcase
      prod_in = PROD_W'(op_in) * PROD_W'(mul_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         raw_ff     <= raw_mode;
         scale_ff   <= power_scale;
         neg_ff     <= neg_in;
         reading_ff <= raw_reading;
         prod_ff    <= prod_in;
      end
   end

   always_comb begin
      case (scale_ff)
         PS_LOW:  quot = VAL_W'(prod_ff >> LOW_K);
         PS_MID:  quot = VAL_W'(prod_ff >> MID_K);
         PS_INV:  quot = VAL_W'(prod_ff >> INV_K);
         default: quot = '0;
      endcase
      if (raw_ff) begin
         value = $signed({1'b0, reading_ff});
      end else if (scale_ff == PS_KEEP) begin
         value = last_ff;
      end else if (neg_ff) begin
         value = -$signed(quot);
      end else begin
         value = $signed(quot);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff <= '0;
      end else if (valid_ff && advance) begin
         last_ff <= value;
      end
   end

   assign sample.valid  = valid_ff;
   assign sample.scaled = value;

endmodule

// ----- hdl/crat_cell.sv -----
// One window cell: holds a stored value and hands it to the next cell on each shift.
module crat_cell (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                shift,
   input  logic signed [crat_pkg::VAL_W-1:0]   value_in,
   output logic signed [crat_pkg::VAL_W-1:0]   value_out
);
   import crat_pkg::*;

   logic signed [VAL_W-1:0] value_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         value_ff <= '0;
      end else if (shift) begin
         value_ff <= value_in;
      end
   end

   assign value_out = value_ff;

endmodule

// ----- hdl/crat_window.sv -----
// Moving window: chain of cells with a running total of their contents.
module crat_window (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  crat_pkg::sample_type sample,
   output crat_pkg::sum_type    sum
);
   import crat_pkg::*;

   logic signed [VAL_W-1:0]   tap [WINDOW_LEN];
   logic                      shift;
   logic signed [TOTAL_W-1:0] total_ff;
   logic signed [TOTAL_W-1:0] total_in;
   logic                      valid_ff;
   logic signed [VAL_W-1:0]   scaled_ff;

   assign shift = sample.valid && advance;

   crat_cell u_head (
      .clock     (clock),
      .reset     (reset),
      .shift     (shift),
      .value_in  (sample.scaled),
      .value_out (tap[0])
   );

   for (genvar i = 1; i < WINDOW_LEN; i++) begin : g_cell
      crat_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .shift     (shift),
         .value_in  (tap[i-1]),
         .value_out (tap[i])
      );
   end

   assign total_in = total_ff + TOTAL_W'(sample.scaled) - TOTAL_W'(tap[WINDOW_LEN-1]);

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= sample.valid;
         if (sample.valid) begin
            total_ff <= total_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         scaled_ff <= sample.scaled;
      end
   end

   assign sum.valid  = valid_ff;
   assign sum.scaled = scaled_ff;
   assign sum.total  = total_ff;

endmodule

// ----- hdl/crat_average.sv -----
// Average and threshold: reciprocal multiply of the total, then sign, compare and output register.
module crat_average (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                advance,
   input  crat_pkg::sum_type                   sum,
   input  logic signed [crat_pkg::THR_W-1:0]   red_threshold,
   output logic                                rsp_valid,
   output logic                                is_red,
   output logic signed [crat_pkg::VAL_W-1:0]   average,
   output logic signed [crat_pkg::VAL_W-1:0]   scaled_value
);
   import crat_pkg::*;

   logic [MAG_W-1:0]          mag;
   logic [AVG_P_W-1:0]        prod_in;
   logic                      valid_ff;
   logic                      neg_ff;
   logic signed [VAL_W-1:0]   scaled_ff;
   logic [AVG_P_W-1:0]        prod_ff;

   logic [MAG_W-1:0]          avg_mag;
   logic signed [TOTAL_W-1:0] avg;
   logic                      red_in;

   logic                      out_valid_ff;
   logic                      red_ff;
   logic signed [VAL_W-1:0]   average_ff;
   logic signed [VAL_W-1:0]   out_scaled_ff;

   assign mag     = sum.total[TOTAL_W-1] ? MAG_W'(-sum.total) : MAG_W'(sum.total);
   assign prod_in = AVG_P_W'(mag) * AVG_P_W'(AVG_M);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff     <= sum.valid;
         out_valid_ff <= valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         neg_ff    <= sum.total[TOTAL_W-1];
         scaled_ff <= sum.scaled;
         prod_ff   <= prod_in;
      end
   end

   always_comb begin
      avg_mag = MAG_W'(prod_ff >> AVG_K);
      if (neg_ff) begin
         avg = -$signed({1'b0, avg_mag});
      end else begin
         avg = $signed({1'b0, avg_mag});
      end
      red_in = avg > TOTAL_W'(red_threshold);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         red_ff        <= red_in;
         average_ff    <= VAL_W'(avg);
         out_scaled_ff <= scaled_ff;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign is_red       = red_ff;
   assign average      = average_ff;
   assign scaled_value = out_scaled_ff;

endmodule

// ----- hdl/color_reading_average_threshold.sv -----
// Top level of the color reading moving average threshold detector.
//
//   channel  direction  handshake          payload
//   req      in         tvalid/tready      tdata[15:0] raw_reading
//   rsp      out        tvalid/tready      tdata: average, scaled_value; tuser: is_red
//   csr      in         psel/penable/pwrite registers power_scale, raw_mode, red_threshold
//
// One request per cycle unless a result waits on rsp_tready; a result passes through four registered stages.
// The four stages are scale multiply, scale select plus window update,
// average multiply, and the output register.
// All stages hold together while a result waits on rsp_tready.
// Reset clears the window cells, the running total and the pipeline.
module color_reading_average_threshold (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [15:0]                       req_tdata,   // [15:0] raw_reading
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [39:0]                       rsp_tdata,   // [16:0] average, [33:17] scaled_value
   output logic                              rsp_tuser,   // [0] is_red
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [crat_pkg::ADDR_W-1:0]       csr_paddr,
   input  logic [crat_pkg::DATA_W-1:0]       csr_pwdata,
   output logic [crat_pkg::DATA_W-1:0]       csr_prdata,
   output logic                              csr_pready
);
   import crat_pkg::*;

   logic [SCALE_W-1:0]      power_scale_ff;
   logic                    raw_mode_ff;
   logic signed [THR_W-1:0] red_threshold_ff;
   logic                    csr_write;
   logic [1:0]              csr_index;

   logic                    advance;
   sample_type              sample;
   sum_type                 sum;
   logic                    is_red;
   logic signed [VAL_W-1:0] average;
   logic signed [VAL_W-1:0] scaled_value;

   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[3:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         power_scale_ff   <= POWER_SCALE_RESET;
         raw_mode_ff      <= 1'b0;
         red_threshold_ff <= THRESHOLD_RESET;
      end else if (csr_write) begin
         case (csr_index)
            REG_POWER_SCALE:   power_scale_ff   <= csr_pwdata[SCALE_W-1:0];
            REG_RAW_MODE:      raw_mode_ff      <= csr_pwdata[0];
            REG_RED_THRESHOLD: red_threshold_ff <= $signed(csr_pwdata[THR_W-1:0]);
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_POWER_SCALE:   csr_prdata = DATA_W'(power_scale_ff);
         REG_RAW_MODE:      csr_prdata = DATA_W'(raw_mode_ff);
         REG_RED_THRESHOLD: csr_prdata = DATA_W'(unsigned'(red_threshold_ff));
         default:           csr_prdata = '0;
      endcase
   end

   assign advance    = !rsp_tvalid || rsp_tready;
   assign req_tready = advance;

   crat_scale u_scale (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .req_valid   (req_tvalid),
      .raw_reading (req_tdata),
      .power_scale (power_scale_ff),
      .raw_mode    (raw_mode_ff),
      .sample      (sample)
   );

   crat_window u_window (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .sample  (sample),
      .sum     (sum)
   );

   crat_average u_average (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .sum           (sum),
      .red_threshold (red_threshold_ff),
      .rsp_valid     (rsp_tvalid),
      .is_red        (is_red),
      .average       (average),
      .scaled_value  (scaled_value)
   );

   assign rsp_tdata = {6'b0, scaled_value, average};
   assign rsp_tuser = is_red;

endmodule

// ----- tb/sv/tb_color_reading_average_threshold.sv -----
// Self-checking testbench for the color reading moving average threshold detector.
module tb_color_reading_average_threshold;
   import crat_pkg::*;

   localparam logic [1:0] REG_UNUSED = 2'd3;
   localparam int RUN_LIMIT     = 400000;
   localparam int RANDOM_PHASES = 12;
   localparam int PHASE_ITEMS   = 55;

   typedef struct {
      logic                    is_red;
      logic signed [VAL_W-1:0] average;
      logic signed [VAL_W-1:0] scaled;
   } red_reading_type;

   class red_average_scoreboard;
      logic [SCALE_W-1:0]      power_scale;
      logic                    raw_mode;
      logic signed [THR_W-1:0] red_threshold;
      longint                  window_cells[WINDOW_LEN];
      int                      write_pos;
      longint                  running_total;
      longint                  last_scaled;
      red_reading_type         pending_results[$];
      int                      mismatches;

      function new();
         power_scale   = POWER_SCALE_RESET;
         raw_mode      = 1'b0;
         red_threshold = THRESHOLD_RESET;
         foreach (window_cells[i]) window_cells[i] = 0;
         write_pos     = 0;
         running_total = 0;
         last_scaled   = 0;
         mismatches    = 0;
      endfunction

      function void set_register(logic [1:0] index, logic [DATA_W-1:0] value);
         case (index)
            REG_POWER_SCALE:   power_scale = value[SCALE_W-1:0];
            REG_RAW_MODE:      raw_mode = value[0];
            REG_RED_THRESHOLD: red_threshold = value[THR_W-1:0];
            default: ;
         endcase
      endfunction

      function void note_reading(logic [IN_W-1:0] raw);
         longint          x;
         longint          avg;
         red_reading_type want;
         x = raw;
         if (raw_mode) begin
            last_scaled = x;
         end else begin
            case (power_scale)
               PS_LOW: last_scaled = (x * 100) / 160;
               PS_MID: last_scaled = (x * 100) / 1400;
               PS_INV: last_scaled = ((x - 1200) * 100) / (25 - 1200);
               default: ;
            endcase
         end
         running_total -= window_cells[write_pos];
         window_cells[write_pos] = last_scaled;
         running_total += last_scaled;
         write_pos = (write_pos + 1) % WINDOW_LEN;
         avg = running_total / WINDOW_LEN;
         want.is_red  = (avg > longint'(red_threshold));
         want.average = avg[VAL_W-1:0];
         want.scaled  = last_scaled[VAL_W-1:0];
         pending_results.push_back(want);
      endfunction

      function void check_result(logic [39:0] tdata, logic tuser);
         red_reading_type want;
         red_reading_type got;
         got.is_red  = tuser;
         got.average = tdata[16:0];
         got.scaled  = tdata[33:17];
         if (pending_results.size() == 0) begin
            $display("%0t unexpected result: average %0d scaled %0d is_red %0b",
                     $time, got.average, got.scaled, got.is_red);
            mismatches++;
            return;
         end
         want = pending_results.pop_front();
         if (got.scaled !== want.scaled) begin
            $display("%0t scaled_value mismatch: expected %0d actual %0d",
                     $time, want.scaled, got.scaled);
            mismatches++;
         end
         if (got.average !== want.average) begin
            $display("%0t average mismatch: expected %0d actual %0d",
                     $time, want.average, got.average);
            mismatches++;
         end
         if (got.is_red !== want.is_red) begin
            $display("%0t is_red mismatch: expected %0b actual %0b",
                     $time, want.is_red, got.is_red);
            mismatches++;
         end
      endfunction
   endclass

   logic                clock;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [15:0]         req_tdata;    // [15:0] raw_reading
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [39:0]         rsp_tdata;    // [16:0] average, [33:17] scaled_value
   logic                rsp_tuser;    // [0] is_red
   logic                csr_psel;
   logic                csr_penable;
   logic                csr_pwrite;
   logic [ADDR_W-1:0]   csr_paddr;
   logic [DATA_W-1:0]   csr_pwdata;
   logic [DATA_W-1:0]   csr_prdata;
   logic                csr_pready;

   red_average_scoreboard tracker = new();
   bit                    sender_steady;
   bit                    receiver_steady;
   logic [15:0]           picks[$];

   color_reading_average_threshold u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #(RUN_LIMIT);
      $display("TEST FAILED");
      $finish;
   end

   task automatic send_reading(input logic [15:0] raw);
      int gap;
      gap = sender_steady ? 0 : $urandom_range(0, 8);
      if ($urandom_range(0, 39) == 0) sender_steady = !sender_steady;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= raw;
      do @(posedge clock); while (!req_tready);
      tracker.note_reading(raw);
   endtask

   task automatic send_list(input logic [15:0] readings[$]);
      foreach (readings[i]) send_reading(readings[i]);
   endtask

   // hold requests until every expected result is back
   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (tracker.pending_results.size() != 0);
   endtask

   task automatic csr_write(input logic [1:0] index, input logic [DATA_W-1:0] value);
      logic [DATA_W-1:0] keep;
      case (index)
         REG_POWER_SCALE:   keep = 32'h3;
         REG_RAW_MODE:      keep = 32'h1;
         REG_RED_THRESHOLD: keep = 32'hFFFF;
         default:           keep = 32'h0;
      endcase
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= ($urandom() & ~keep) | (value & keep);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      tracker.set_register(index, value);
      @(posedge clock);
   endtask

   task automatic set_mode(input logic [1:0] scale, input logic raw,
                           input logic [15:0] threshold);
      drain_results();
      repeat (6) @(posedge clock);
      csr_write(REG_POWER_SCALE, 32'(scale));
      csr_write(REG_RAW_MODE, 32'(raw));
      csr_write(REG_RED_THRESHOLD, 32'(threshold));
   endtask

   function automatic logic [15:0] pick_reading(input logic [15:0] base);
      logic [15:0] edges[8];
      edges = '{16'd0, 16'd24, 16'd25, 16'd160, 16'd1200, 16'd1201, 16'd1400, 16'hFFFF};
      case ($urandom_range(0, 9))
         0, 1, 2: return 16'($urandom());
         3, 4, 5: return base + 16'($urandom_range(0, 100));
         6, 7:    return 16'($urandom_range(0, 1500));
         8:       return edges[$urandom_range(0, 7)];
         default: return 16'($urandom_range(0, 200));
      endcase
   endfunction

   initial begin
      rsp_tready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         int stall;
         stall = receiver_steady ? 0 : $urandom_range(0, 8);
         if ($urandom_range(0, 49) == 0) receiver_steady = !receiver_steady;
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         tracker.check_result(rsp_tdata, rsp_tuser);
      end
   end

   initial begin
      logic [1:0]  scale;
      logic        raw;
      logic [15:0] threshold;
      logic [15:0] base;
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // reset settings: mid map
      picks = {16'd0, 16'd1400, 16'hFFFF, 16'd700};
      send_list(picks);
      // low map
      set_mode(PS_LOW, 1'b0, 16'd75);
      picks = {16'd0, 16'd160, 16'd159, 16'hFFFF};
      send_list(picks);
      // inverted map, lowest threshold
      set_mode(PS_INV, 1'b0, 16'h8000);
      picks = {16'd1200, 16'd25, 16'd24, 16'd0, 16'd1201, 16'hFFFF};
      send_list(picks);
      // keep previous value
      set_mode(PS_KEEP, 1'b0, 16'h8000);
      picks = {16'd12345, 16'd0};
      send_list(picks);
      // raw mode wins over keep, highest threshold
      set_mode(PS_KEEP, 1'b1, 16'h7FFF);
      picks = {16'hFFFF, 16'h8000, 16'd1};
      send_list(picks);
      // unused register index: no effect
      drain_results();
      repeat (6) @(posedge clock);
      csr_write(REG_UNUSED, 32'h0);
      picks = {16'h5555, 16'hAAAA};
      send_list(picks);

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         scale = 2'($urandom_range(0, 3));
         raw   = ($urandom_range(0, 3) == 0);
         case ($urandom_range(0, 5))
            0:       threshold = 16'h8000;
            1:       threshold = 16'h7FFF;
            2:       threshold = 16'($urandom());
            default: threshold = raw ? 16'($urandom_range(0, 32767))
                                     : 16'($urandom_range(0, 250) - 50);
         endcase
         set_mode(scale, raw, threshold);
         base = 16'($urandom_range(0, 2000));
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (phase == 5 && n == 27) drain_results();
            send_reading(pick_reading(base));
         end
      end

      drain_results();
      repeat (16) @(posedge clock);
      if (tracker.mismatches == 0 && tracker.pending_results.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

// ----- sim.f -----
hdl/crat_pkg.sv
hdl/crat_scale.sv
hdl/crat_cell.sv
hdl/crat_window.sv
hdl/crat_average.sv
hdl/color_reading_average_threshold.sv
tb/sv/tb_color_reading_average_threshold.sv
